>>> rtl/core/smt_pkg.sv
// Shared types, codes and constants of the staged maturation tracker.
// Used by the tracker top level and by its divider unit; no dependencies.
package smt_pkg;

  localparam int ID_W            = 32;
  localparam int Q_W             = 17;
  localparam int STEP_W          = 20;
  localparam int LEN_W           = 20;
  localparam int RATE_W          = 17;
  localparam int LIMIT_W         = 11;
  localparam int CFG_W           = 20;
  localparam int DIV_DEN_W       = 20;
  localparam int DIV_Q_W         = 17;
  localparam int DIV_NUM_W       = DIV_DEN_W + DIV_Q_W;
  localparam int DEF_MAX_ENTRIES = 1024;

  localparam logic [Q_W-1:0]     ONE_Q16        = 17'd65536;
  localparam logic [Q_W-1:0]     HALF_Q16       = 17'd32768;
  localparam logic [STEP_W-1:0]  PROGENITOR_LEN = 20'd100;
  localparam logic [STEP_W-1:0]  IMMATURE_LEN   = 20'd400;
  localparam logic [LEN_W-1:0]   EARLY_LEN      = 20'd500;
  localparam logic [LEN_W-1:0]   MIN_LEN        = 20'd501;

  localparam logic [LEN_W-1:0]   RST_LENGTH = 20'd1000;
  localparam logic [RATE_W-1:0]  RST_RATE   = 17'd6554;
  localparam logic [LIMIT_W-1:0] RST_LIMIT  = 11'd1024;

  typedef enum logic [1:0] {
    REG_LENGTH = 2'd0,
    REG_RATE   = 2'd1,
    REG_LIMIT  = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAGE_PROGENITOR  = 2'd0,
    STAGE_IMMATURE    = 2'd1,
    STAGE_INTEGRATING = 2'd2,
    STAGE_MATURE      = 2'd3
  } stage_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DIV,
    S_PSTART,
    S_PWAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    stage_t            stage;
    logic [STEP_W-1:0] step;
    logic [Q_W-1:0]    scale;
  } entry_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quot;
  } div_rsp_t;

endpackage

>>> rtl/core/smt_div.sv
// Restoring divider, one quotient bit per cycle, for the maturation tracker.
// Depends on smt_pkg; the quotient must fit in DIV_Q_W bits.
module smt_div
  import smt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_Q_W-1:0]   low_bits;
  logic [DIV_Q_W-1:0]   quot;
  logic [DIV_DEN_W-1:0] den;
  logic [4:0]           cnt;
  logic                 done;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  assign trial = {rem, low_bits[DIV_Q_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == 5'd1);
      if (req.start) begin
        cnt <= 5'(DIV_Q_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 5'd1;
      end
    end
    if (req.start) begin
      rem      <= req.num[DIV_NUM_W-1:DIV_Q_W];
      low_bits <= req.num[DIV_Q_W-1:0];
      den      <= req.den;
      quot     <= '0;
    end else if (cnt != '0) begin
      rem      <= fits ? DIV_DEN_W'(trial - {1'b0, den}) : trial[DIV_DEN_W-1:0];
      low_bits <= {low_bits[DIV_Q_W-2:0], 1'b0};
      quot     <= {quot[DIV_Q_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

>>> rtl/core/staged_maturation_tracker.sv
// Staged maturation tracker: top level with the entry memories and sequencer.
// Depends on smt_pkg and on the divider unit smt_div.
//
// Usage: a request (cmd, req_id) is taken at a rising edge where start is
// high and busy is low. Add appends a progenitor entry unless the table is
// full, tick advances every non-mature entry one step, and lookup returns the
// scale of the first entry with a matching id (1.0 when none matches).
// Exactly one result is produced per request: done is high for one cycle with
// status, lookup_scale, progress, rate_scale and tracked_count valid. The
// receiver cannot stall; the result must be taken in that cycle.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while busy is low, which the block does not enforce.
// Writes take effect at once and there is no read-back.
// An add or no-op scans no entries. A tick reads the entries one at a time
// and waits for the shared bit-serial divider, which forms both the
// integrating ramp and the progress fraction, on each integrating entry
// that is not finishing; a lookup reads entries until a match. Any request
// that leaves the table empty skips the scan and the division.
// Reset clears the entry counts and restores the configuration registers;
// the memory contents are left as they are since only filled entries are read.
module staged_maturation_tracker
  import smt_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  parameter int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic [ID_W-1:0]    req_id,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  output logic               done,
  output logic               status,
  output logic [Q_W-1:0]     lookup_scale,
  output logic [Q_W-1:0]     progress,
  output logic [Q_W-1:0]     rate_scale,
  output logic [CNT_W-1:0]   tracked_count
);

  // Entry storage: ids in one memory, stage/step/scale in the other.
  logic [ID_W-1:0] ids_mem [MAX_ENTRIES];
  entry_t          st_mem  [MAX_ENTRIES];
  logic [ID_W-1:0] ids_rd;
  entry_t          st_rd;

  state_t state, state_next;

  // Configuration registers.
  logic [LEN_W-1:0]   maturation_length;
  logic [RATE_W-1:0]  reduced_rate_scale;
  logic [LIMIT_W-1:0] table_limit;

  // Request and result registers.
  cmd_t             cmd_q;
  logic [ID_W-1:0]  id_q;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] entry_total;
  logic [CNT_W-1:0] mature_total;
  logic             status_q;
  logic [Q_W-1:0]   scale_q;
  logic [Q_W-1:0]   prog_q;

  logic accept;
  logic full;
  logic last;
  logic adv;

  // Memory write port.
  logic            ids_we;
  logic            st_we;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_entry;

  // Per-entry tick evaluation.
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  dur;
  logic [STEP_W-1:0] n;
  logic [15:0]       imm_base;
  logic [13:0]       imm_y;
  logic [26:0]       imm_prod;
  logic [Q_W-1:0]    imm_scale;
  entry_t            ev_entry;
  logic              ev_write;
  logic              ev_div;
  logic              ev_mature;
  logic              id_match;

  div_req_t div_req;
  div_rsp_t div_rsp;

  smt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign accept = start && (state == S_IDLE);
  assign full   = (32'(entry_total) >= 32'(table_limit)) ||
                  (32'(entry_total) >= 32'(MAX_ENTRIES));
  assign last   = (idx + CNT_W'(1)) == entry_total;
  assign id_match = (ids_rd == id_q);

  // A length below the minimum behaves as the minimum, giving a ramp of one.
  assign len_eff = (maturation_length < MIN_LEN) ? MIN_LEN : maturation_length;
  assign dur     = len_eff - EARLY_LEN;
  assign n       = st_rd.step + STEP_W'(1);

  // Immature ramp: floor(32768 * n / 400) = 81 * n + floor(23 * n / 25),
  // the last term via a reciprocal that is exact for n below 400.
  assign imm_base  = 16'(n[8:0]) * 16'd81;
  assign imm_y     = 14'(n[8:0]) * 14'd23;
  assign imm_prod  = 27'(imm_y) * 27'd5243;
  assign imm_scale = Q_W'(imm_base) + Q_W'(imm_prod[26:17]);

  always_comb begin
    ev_entry  = st_rd;
    ev_write  = 1'b1;
    ev_div    = 1'b0;
    ev_mature = 1'b0;
    unique case (st_rd.stage)
      STAGE_PROGENITOR: begin
        ev_entry.scale = '0;
        if (n >= PROGENITOR_LEN) begin
          ev_entry.stage = STAGE_IMMATURE;
          ev_entry.step  = '0;
        end else begin
          ev_entry.step = n;
        end
      end
      STAGE_IMMATURE: begin
        if (n >= IMMATURE_LEN) begin
          ev_entry.stage = STAGE_INTEGRATING;
          ev_entry.step  = '0;
          ev_entry.scale = HALF_Q16;
        end else begin
          ev_entry.step  = n;
          ev_entry.scale = imm_scale;
        end
      end
      STAGE_INTEGRATING: begin
        ev_entry.step = n;
        if (n >= dur) begin
          ev_entry.stage = STAGE_MATURE;
          ev_entry.scale = ONE_Q16;
          ev_mature      = 1'b1;
        end else begin
          ev_write = 1'b0;
          ev_div   = 1'b1;
        end
      end
      STAGE_MATURE: begin
        ev_write = 1'b0;
      end
    endcase
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if ((cmd == CMD_TICK || cmd == CMD_LOOKUP) && entry_total != '0) begin
            state_next = S_READ;
          end else begin
            state_next = S_PSTART;
          end
        end
      end
      S_READ: state_next = S_EVAL;
      S_EVAL: begin
        priority if (cmd_q == CMD_TICK && ev_div) begin
          state_next = S_DIV;
        end else if (cmd_q == CMD_LOOKUP && id_match) begin
          state_next = S_PSTART;
        end else if (last) begin
          state_next = S_PSTART;
        end else begin
          state_next = S_READ;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_next = last ? S_PSTART : S_READ;
        end
      end
      S_PSTART: state_next = (entry_total == '0) ? S_OUT : S_PWAIT;
      S_PWAIT:  state_next = div_rsp.done ? S_OUT : S_PWAIT;
      S_OUT:    state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Control outputs, memory write port and divider request.
  always_comb begin
    busy     = (state != S_IDLE);
    done     = (state == S_OUT);
    ids_we   = 1'b0;
    st_we    = 1'b0;
    wr_addr  = idx[AW-1:0];
    wr_entry = ev_entry;
    adv      = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = DIV_NUM_W'({n, 15'b0});
    div_req.den   = dur;
    unique case (state)
      S_IDLE: begin
        if (start && cmd == CMD_ADD && !full) begin
          ids_we   = 1'b1;
          st_we    = 1'b1;
          wr_addr  = entry_total[AW-1:0];
          wr_entry = '{stage: STAGE_PROGENITOR, step: '0, scale: '0};
        end
      end
      S_EVAL: begin
        if (cmd_q == CMD_TICK) begin
          st_we         = ev_write;
          div_req.start = ev_div;
          adv           = !ev_div && !last;
        end else begin
          adv = !id_match && !last;
        end
      end
      S_DIV: begin
        wr_entry.scale = HALF_Q16 + Q_W'(div_rsp.quot[14:0]);
        st_we          = div_rsp.done;
        adv            = div_rsp.done && !last;
      end
      S_PSTART: begin
        div_req.start = (entry_total != '0);
        div_req.num   = DIV_NUM_W'({mature_total, 16'b0});
        div_req.den   = DIV_DEN_W'(entry_total);
      end
      S_PWAIT: begin
        div_req.num = DIV_NUM_W'({mature_total, 16'b0});
        div_req.den = DIV_DEN_W'(entry_total);
      end
      default: begin
        busy = (state != S_IDLE);
      end
    endcase
  end

  // Entry memories: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (ids_we) begin
      ids_mem[wr_addr] <= req_id;
    end
    if (st_we) begin
      st_mem[wr_addr] <= wr_entry;
    end
    if (state == S_READ) begin
      ids_rd <= ids_mem[idx[AW-1:0]];
      st_rd  <= st_mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      entry_total        <= '0;
      mature_total       <= '0;
      maturation_length  <= RST_LENGTH;
      reduced_rate_scale <= RST_RATE;
      table_limit        <= RST_LIMIT;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_LENGTH: maturation_length  <= cfg_data[LEN_W-1:0];
          REG_RATE:   reduced_rate_scale <= cfg_data[RATE_W-1:0];
          REG_LIMIT:  table_limit        <= cfg_data[LIMIT_W-1:0];
          REG_NONE:   table_limit        <= table_limit;
        endcase
      end
      if (ids_we) begin
        entry_total <= entry_total + CNT_W'(1);
      end
      if (state == S_EVAL && cmd_q == CMD_TICK && ev_mature) begin
        mature_total <= mature_total + CNT_W'(1);
      end
    end
  end

  // Request and result datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= cmd_t'(cmd);
      id_q     <= req_id;
      idx      <= '0;
      status_q <= (cmd == CMD_ADD) && full;
      scale_q  <= (cmd == CMD_LOOKUP) ? ONE_Q16 : '0;
    end
    if (adv) begin
      idx <= idx + CNT_W'(1);
    end
    if (state == S_EVAL && cmd_q == CMD_LOOKUP && id_match) begin
      scale_q <= st_rd.scale;
    end
    if (state == S_PSTART) begin
      prog_q <= ONE_Q16;
    end else if (state == S_PWAIT && div_rsp.done) begin
      prog_q <= div_rsp.quot;
    end
  end

  assign status        = status_q;
  assign lookup_scale  = scale_q;
  assign progress      = prog_q;
  assign rate_scale    = (entry_total == '0 || mature_total == entry_total) ?
                         ONE_Q16 : reduced_rate_scale;
  assign tracked_count = entry_total;

  // A result strobe lasts exactly one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held");

  // Mature entries never outnumber stored entries.
  a_mature_le_total: assert property (@(posedge clk) disable iff (rst)
    mature_total <= entry_total) else $error("mature count exceeds total");

  // The table never holds more than its depth.
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    32'(entry_total) <= 32'(MAX_ENTRIES)) else $error("table overflow");

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request dropped");

  // Entry writes never happen while a result is being presented.
  a_no_write_out: assert property (@(posedge clk) disable iff (rst)
    done |-> !st_we && !ids_we) else $error("write during result");

endmodule

>>> tb/smt_checker.sv
// Checker for the staged maturation tracker: mirrors the configuration writes,
// predicts one result per accepted request and compares it with the strobed result.
// Depends on smt_pkg for the command, stage and register codes.
`timescale 1ns / 100ps

module smt_checker
  import smt_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         cmd,
  input  logic [ID_W-1:0]    req_id,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               done,
  input  logic               status,
  input  logic [Q_W-1:0]     lookup_scale,
  input  logic [Q_W-1:0]     progress,
  input  logic [Q_W-1:0]     rate_scale,
  input  logic [10:0]        tracked_count,
  output int                 mismatch_count,
  output int                 outstanding
);

  typedef struct packed {
    logic           status;
    logic [Q_W-1:0] scale;
    logic [Q_W-1:0] progress;
    logic [Q_W-1:0] rate;
    logic [10:0]    count;
  } tracker_result_t;

  logic [ID_W-1:0]   ids   [MAX_ENTRIES];
  stage_t            stages[MAX_ENTRIES];
  logic [STEP_W-1:0] steps [MAX_ENTRIES];
  logic [Q_W-1:0]    scales[MAX_ENTRIES];
  int                entry_total;
  int                mature_total;
  logic [LEN_W-1:0]  length_reg;
  logic [RATE_W-1:0] rate_reg;
  logic [LIMIT_W-1:0] limit_reg;
  tracker_result_t   expected_results[$];

  // Advances one entry by a tick through the progenitor, immature and integrating stages.
  task automatic age_entry(int i);
    longint dur;
    longint n;
    dur = longint'(((length_reg < MIN_LEN) ? MIN_LEN : length_reg) - EARLY_LEN);
    if (stages[i] != STAGE_MATURE) begin
      n = longint'(steps[i]) + 1;
      steps[i] = STEP_W'(n);
      case (stages[i])
        STAGE_PROGENITOR: begin
          scales[i] = '0;
          if (n >= 100) begin
            stages[i] = STAGE_IMMATURE;
            steps[i] = '0;
          end
        end
        STAGE_IMMATURE: begin
          scales[i] = Q_W'(((32768 * n) / 400 > 32768) ? 32768 : (32768 * n) / 400);
          if (n >= 400) begin
            stages[i] = STAGE_INTEGRATING;
            steps[i] = '0;
          end
        end
        default: begin
          if (n >= dur) begin
            stages[i] = STAGE_MATURE;
            scales[i] = ONE_Q16;
            mature_total++;
          end else begin
            scales[i] = Q_W'(32768 + (32768 * n) / dur);
          end
        end
      endcase
    end
  endtask

  task automatic predict_request(cmd_t c, logic [ID_W-1:0] id);
    tracker_result_t r;
    int limit;
    limit = (limit_reg < MAX_ENTRIES) ? limit_reg : MAX_ENTRIES;
    r = '0;
    case (c)
      CMD_ADD: begin
        if (entry_total >= limit) begin
          r.status = 1'b1;
        end else begin
          ids[entry_total] = id;
          stages[entry_total] = STAGE_PROGENITOR;
          steps[entry_total] = '0;
          scales[entry_total] = '0;
          entry_total++;
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < entry_total; i++) age_entry(i);
      end
      CMD_LOOKUP: begin
        r.scale = ONE_Q16;
        for (int i = 0; i < entry_total; i++) begin
          if (ids[i] == id) begin
            r.scale = scales[i];
            break;
          end
        end
      end
      default: ;
    endcase
    if (entry_total == 0) begin
      r.progress = ONE_Q16;
      r.rate = ONE_Q16;
    end else begin
      r.progress = Q_W'((longint'(mature_total) * 65536) / entry_total);
      r.rate = (mature_total < entry_total) ? rate_reg : ONE_Q16;
    end
    r.count = 11'(entry_total);
    expected_results.push_back(r);
  endtask

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    tracker_result_t want;
    if (rst) begin
      entry_total = 0;
      mature_total = 0;
      length_reg = RST_LENGTH;
      rate_reg = RST_RATE;
      limit_reg = RST_LIMIT;
      expected_results.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_LENGTH: length_reg = cfg_data[LEN_W-1:0];
          REG_RATE:   rate_reg = cfg_data[RATE_W-1:0];
          REG_LIMIT:  limit_reg = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) predict_request(cmd_t'(cmd), req_id);
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request waiting, actual count %0d",
                   $time, tracked_count);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("status", want.status, status);
          compare_field("lookup_scale", want.scale, lookup_scale);
          compare_field("progress", want.progress, progress);
          compare_field("rate_scale", want.rate, rate_scale);
          compare_field("tracked_count", want.count, tracked_count);
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

>>> tb/staged_maturation_tracker_test.sv
// Top of the staged maturation tracker test: clock, reset, request and register stimulus.
// Depends on smt_pkg, the tracker RTL and the smt_checker module.
`timescale 1ns / 100ps

module staged_maturation_tracker_test;
  import smt_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [1:0]        cmd = CMD_NOP;
  logic [ID_W-1:0]   req_id = '0;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = REG_NONE;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              busy;
  logic              done;
  logic              status;
  logic [Q_W-1:0]    lookup_scale;
  logic [Q_W-1:0]    progress;
  logic [Q_W-1:0]    rate_scale;
  logic [10:0]       tracked_count;
  int                mismatch_count;
  int                outstanding;

  // Random idle bursts on the request side are enabled only for the early phases.
  bit                idle_on;
  logic [ID_W-1:0]   added_ids[$];
  int                quiet_cycles;

  initial begin
    forever #2 clk = ~clk;
  end

  staged_maturation_tracker i_dut (
    .clk, .rst, .start, .busy, .cmd, .req_id, .cfg_we, .cfg_index, .cfg_data,
    .done, .status, .lookup_scale, .progress, .rate_scale, .tracked_count
  );

  smt_checker i_checker (
    .clk, .rst, .start, .busy, .cmd, .req_id, .cfg_we, .cfg_index, .cfg_data,
    .done, .status, .lookup_scale, .progress, .rate_scale, .tracked_count,
    .mismatch_count, .outstanding
  );

  // The watchdog counts edges at which neither a request nor a result is taken.
  // The slowest legal request is a tick over a full table.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Issues one request and returns at the edge where it is accepted. Start is
  // left high so that back-to-back requests need no extra cycle.
  task automatic issue_request(cmd_t c, logic [ID_W-1:0] id);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    req_id <= id;
    if (c == CMD_ADD) added_ids.push_back(id);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Holds off new requests until every predicted result has come back.
  task automatic wait_for_idle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly ticks so that entries walk through all stages; lookups mostly hit
  // stored ids, with some random ids, adds and no-ops as noise.
  task automatic random_request();
    int roll;
    logic [ID_W-1:0] id;
    roll = $urandom_range(0, 99);
    id = $urandom();
    if (added_ids.size() != 0 && $urandom_range(0, 9) < 7)
      id = added_ids[$urandom_range(0, added_ids.size() - 1)];
    if (roll < 70) issue_request(CMD_TICK, $urandom());
    else if (roll < 88) issue_request(CMD_LOOKUP, id);
    else if (roll < 96) issue_request(CMD_ADD, $urandom());
    else issue_request(CMD_NOP, $urandom());
  endtask

  initial begin
    idle_on = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on the reset configuration: empty table, id extremes,
    // a duplicate id, an absent id and the unused command.
    issue_request(CMD_LOOKUP, 32'h0);
    issue_request(CMD_NOP, 32'hFFFF_FFFF);
    issue_request(CMD_TICK, 32'h0);
    issue_request(CMD_ADD, 32'h0);
    issue_request(CMD_ADD, 32'hFFFF_FFFF);
    issue_request(CMD_ADD, 32'h0);
    issue_request(CMD_LOOKUP, 32'h0);
    issue_request(CMD_LOOKUP, 32'hFFFF_FFFF);
    issue_request(CMD_LOOKUP, 32'h5555_5555);
    issue_request(CMD_TICK, 32'hAAAA_AAAA);
    issue_request(CMD_LOOKUP, 32'hFFFF_FFFF);
    wait_for_idle();

    // A zero limit refuses every add; the rate register is written beyond its
    // range and the length below the minimum.
    write_register(REG_LIMIT, 20'd0);
    write_register(REG_RATE, 20'hFFFFF);
    write_register(REG_LENGTH, 20'd0);
    issue_request(CMD_ADD, 32'h1234_5678);
    issue_request(CMD_TICK, 32'h0);
    wait_for_idle();

    // Small table with a normal length, nearly all ticks, so that the first
    // entries pass the fixed stages and ramp for a while in the last one.
    write_register(REG_LENGTH, 20'd1000);
    write_register(REG_LIMIT, 20'd6);
    write_register(REG_RATE, 20'd6554);
    repeat (530) begin
      if ($urandom_range(0, 9) == 0) random_request();
      else issue_request(CMD_TICK, $urandom());
    end
    wait_for_idle();

    // Lowering the length mid-ramp finishes the integrating entries at once.
    write_register(REG_LENGTH, 20'd501);
    write_register(REG_RATE, 20'd0);
    repeat (15) random_request();
    wait_for_idle();

    // The limit register keeps only its low bits, here a limit of 8, so the
    // last adds are refused; the longest length keeps new entries ramping.
    idle_on = 1'b0;
    write_register(REG_LENGTH, 20'hFFFFF);
    write_register(REG_LIMIT, 20'hFF808);
    write_register(REG_RATE, 20'd65536);
    repeat (4) issue_request(CMD_ADD, $urandom());
    repeat (10) random_request();
    issue_request(CMD_LOOKUP, 32'h0);

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
